@@ hdl/order_statistic_multiset_top_defines.svh @@
// assertion macros shared by the order statistic multiset block
`ifndef ORDER_STATISTIC_MULTISET_TOP_DEFINES_SVH
`define ORDER_STATISTIC_MULTISET_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define OSM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// condition never holds
`define OSM_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition");

`endif

@@ hdl/osm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_pkg
// types, action codes and defaults for the order statistic multiset
// ----------------------------------------------------------------------------
package osm_pkg;

   localparam int KEY_BITS_DEF   = 16;
   localparam int COUNT_BITS_DEF = 20;

   localparam logic [2:0] ACT_INSERT    = 3'd0;
   localparam logic [2:0] ACT_ERASE_ALL = 3'd1;
   localparam logic [2:0] ACT_ERASE_AMT = 3'd2;
   localparam logic [2:0] ACT_COUNT     = 3'd3;
   localparam logic [2:0] ACT_RANK      = 3'd4;
   localparam logic [2:0] ACT_SELECT    = 3'd5;
   localparam logic [2:0] ACT_RANK_INS  = 3'd6;
   localparam logic [2:0] ACT_CLEAR     = 3'd7;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] key;
      logic [19:0] amount;
   } req_type;

   typedef struct packed {
      logic [19:0] answer;
      logic [19:0] total_size;
      logic        error_flag;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    is_clear;
   } cmd_type;

endpackage

@@ hdl/osm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_front
// accepts request transactions, tags clears and queues them for the engine
// ----------------------------------------------------------------------------
module osm_front import osm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;
   cmd_type    new_cmd;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];
   assign push_ok   = req_push && !req_full;

   always_comb begin
      new_cmd.req      = req_data;
      new_cmd.is_clear = (req_data.action == ACT_CLEAR);
      wr_in  = push_ok ? ~wr_ff : wr_ff;
      rd_in  = (cmd_pop && cmd_valid) ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push_ok} - {1'b0, cmd_pop && cmd_valid};
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ff] <= new_cmd;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/osm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_back
// tree walk engine over the node count memory, with the result slot
// ----------------------------------------------------------------------------
`include "order_statistic_multiset_top_defines.svh"
module osm_back import osm_pkg::*; #(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   localparam int NODE_BITS = KEY_BITS + 1;
   localparam int LVL_BITS  = $clog2(KEY_BITS + 1);
   localparam int CMP_BITS  = (COUNT_BITS > 20) ? COUNT_BITS : 20;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_RD_ROOT  = 3'd2;
   localparam logic [2:0] S_RD_LEAF  = 3'd3;
   localparam logic [2:0] S_EVAL     = 3'd4;
   localparam logic [2:0] S_WALK_RD  = 3'd5;
   localparam logic [2:0] S_WALK_UPD = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [COUNT_BITS-1:0] mem [2**NODE_BITS];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic                  mem_we, mem_re;
   logic [NODE_BITS-1:0]  mem_waddr, mem_raddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   logic [2:0]            state_ff, state_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [KEY_BITS-1:0]   kbits_ff, kbits_in;
   logic [LVL_BITS-1:0]   lvl_ff, lvl_in;
   logic [2:0]            act_ff, act_in;
   logic [19:0]           amount_ff, amount_in;
   logic [CMP_BITS-1:0]   idx_ff, idx_in;
   logic [COUNT_BITS-1:0] root_ff, root_in;
   logic [COUNT_BITS-1:0] delta_ff, delta_in;
   logic [COUNT_BITS-1:0] acc_ff, acc_in;
   logic                  err_ff, err_in;
   logic                  upd_ff, upd_in;
   logic                  clr_cmd_ff, clr_cmd_in;
   logic [NODE_BITS-1:0]  clr_cnt_ff, clr_cnt_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;

   logic [63:0]           key_wide, acc_wide, sel_wide, root_wide;
   logic [CMP_BITS-1:0]   amt_ext, data_ext, root_ext;
   logic [COUNT_BITS-1:0] erase_cnt;
   logic                  kbit, go_right;

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      key_wide  = 64'(cmd.req.key);
      acc_wide  = 64'(acc_ff);
      sel_wide  = 64'(node_ff[KEY_BITS-1:0]);
      root_wide = 64'(root_ff);
      amt_ext   = CMP_BITS'(amount_ff);
      data_ext  = CMP_BITS'(rdata_ff);
      root_ext  = CMP_BITS'(root_ff);
      erase_cnt = (amt_ext < data_ext) ? COUNT_BITS'(amount_ff) : rdata_ff;
      kbit      = kbits_ff[KEY_BITS-1];
      go_right  = !(idx_ff < data_ext);

      state_in     = state_ff;
      node_in      = node_ff;
      key_in       = key_ff;
      kbits_in     = kbits_ff;
      lvl_in       = lvl_ff;
      act_in       = act_ff;
      amount_in    = amount_ff;
      idx_in       = idx_ff;
      root_in      = root_ff;
      delta_in     = delta_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      upd_in       = upd_ff;
      clr_cmd_in   = clr_cmd_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_load     = 1'b0;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = node_ff;
      mem_raddr    = node_ff;
      mem_wdata    = rdata_ff + delta_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = clr_cmd_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               act_in    = cmd.req.action;
               key_in    = key_wide[KEY_BITS-1:0];
               amount_in = cmd.req.amount;
               err_in    = 1'b0;
               acc_in    = '0;
               if (cmd.is_clear) begin
                  clr_cmd_in = 1'b1;
                  clr_cnt_in = '0;
                  root_in    = '0;
                  state_in   = S_CLEAR;
               end else begin
                  state_in = S_RD_ROOT;
               end
            end
         end
         S_RD_ROOT: begin
            mem_re    = 1'b1;
            mem_raddr = NODE_BITS'(1);
            state_in  = S_RD_LEAF;
         end
         S_RD_LEAF: begin
            root_in   = rdata_ff;
            mem_re    = 1'b1;
            mem_raddr = {1'b1, key_ff};
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            node_in  = NODE_BITS'(1);
            kbits_in = key_ff;
            lvl_in   = '0;
            upd_in   = 1'b0;
            state_in = S_WALK_RD;
            unique case (act_ff)
               ACT_INSERT: begin
                  if (root_ff == CMAX) begin
                     err_in   = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     delta_in = COUNT_BITS'(1);
                     upd_in   = 1'b1;
                  end
               end
               ACT_ERASE_ALL: begin
                  delta_in = ~rdata_ff + 1'b1;
                  upd_in   = 1'b1;
               end
               ACT_ERASE_AMT: begin
                  delta_in = ~erase_cnt + 1'b1;
                  upd_in   = 1'b1;
               end
               ACT_COUNT: begin
                  acc_in   = rdata_ff;
                  state_in = S_DONE;
               end
               ACT_SELECT: begin
                  err_in = !(amt_ext < root_ext);
                  idx_in = amt_ext;
               end
               ACT_RANK, ACT_RANK_INS: begin
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_WALK_RD: begin
            mem_re    = 1'b1;
            mem_raddr = upd_ff ? node_ff : {node_ff[KEY_BITS-1:0], 1'b0};
            state_in  = S_WALK_UPD;
         end
         S_WALK_UPD: begin
            state_in = S_WALK_RD;
            lvl_in   = lvl_ff + 1'b1;
            kbits_in = kbits_ff << 1;
            if (upd_ff) begin
               mem_we  = 1'b1;
               node_in = {node_ff[KEY_BITS-1:0], kbit};
               if (lvl_ff == '0) begin
                  root_in = mem_wdata;
               end
               if (lvl_ff == LVL_BITS'(KEY_BITS)) begin
                  state_in = S_DONE;
               end
            end else if (act_ff == ACT_SELECT) begin
               node_in = {node_ff[KEY_BITS-1:0], go_right};
               if (go_right) begin
                  idx_in = idx_ff - data_ext;
               end
               if (lvl_ff == LVL_BITS'(KEY_BITS - 1)) begin
                  state_in = S_DONE;
               end
            end else begin
               node_in = {node_ff[KEY_BITS-1:0], kbit};
               if (kbit) begin
                  acc_in = acc_ff + rdata_ff;
               end
               if (lvl_ff == LVL_BITS'(KEY_BITS - 1)) begin
                  state_in = S_DONE;
                  if (act_ff == ACT_RANK_INS) begin
                     if (root_ff == CMAX) begin
                        err_in = 1'b1;
                     end else begin
                        delta_in = COUNT_BITS'(1);
                        upd_in   = 1'b1;
                        node_in  = NODE_BITS'(1);
                        kbits_in = key_ff;
                        lvl_in   = '0;
                        state_in = S_WALK_RD;
                     end
                  end
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_load          = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_in.answer     = (act_ff == ACT_SELECT && !clr_cmd_ff) ?
                                   sel_wide[19:0] : acc_wide[19:0];
               rsp_in.total_size = root_wide[19:0];
               rsp_in.error_flag = err_ff;
               clr_cmd_in        = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      node_ff   <= node_in;
      key_ff    <= key_in;
      kbits_ff  <= kbits_in;
      lvl_ff    <= lvl_in;
      act_ff    <= act_in;
      amount_ff <= amount_in;
      idx_ff    <= idx_in;
      root_ff   <= root_in;
      delta_ff  <= delta_in;
      acc_ff    <= acc_in;
      err_ff    <= err_in;
      upd_ff    <= upd_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_cmd_ff   <= clr_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `OSM_ASSERT_IMPLIES(a_no_pop_in_clear, clock, reset, state_ff == S_CLEAR, !cmd_pop)
   `OSM_ASSERT_IMPLIES(a_we_states, clock, reset, mem_we,
      state_ff == S_CLEAR || state_ff == S_WALK_UPD)
   `OSM_ASSERT_IMPLIES(a_load_free_slot, clock, reset, rsp_load, !rsp_valid_ff || rsp_pop)
   `OSM_ASSERT_NEVER(a_rw_same_cycle, clock, reset, mem_we && mem_re)

endmodule

@@ hdl/order_statistic_multiset_top.sv @@
`timescale 1ns / 1ps
// insert and erase read and write each tree level from root to leaf
// rank and select read each level, count reads root and leaf, rank then insert walks twice
// throughput: one transaction at a time in the engine, which finishes each before taking the next
// clear: sweeps the whole node memory one node per cycle, then answers
// reset: synchronous, active high; the same sweep follows, up to two requests queue meanwhile
// ----------------------------------------------------------------------------
// order_statistic_multiset_top
// multiset of bounded keys kept as a segment tree of counts
// ----------------------------------------------------------------------------
module order_statistic_multiset_top import osm_pkg::*; #(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   osm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   osm_back #(
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the order statistic multiset. A directed table
// runs first, then random traffic. Every response is checked against its
// table row or a sparse per-key count model of the multiset. Both
// handshakes are throttled in several idle phases, and the bench also
// forces the input side to stall and later drains the response queue.
// ----------------------------------------------------------------------------
module tb_top;
   import osm_pkg::*;

   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type rsp;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_push;
   req_type req_data;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;
   logic    rsp_pop;

   int unsigned key_counts[bit [15:0]];
   int unsigned set_size;
   rsp_type     expected_rsp[$];
   row_type     dir_rows[$];
   int          fail_count;
   int          rsp_count;
   int          clear_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_left;
   bit          hold_start;

   order_statistic_multiset_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("timeout at %0t", $time);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned rank_of(bit [15:0] key);
      int unsigned sum;
      sum = 0;
      foreach (key_counts[k])
         if (k < key) sum += key_counts[k];
      return sum;
   endfunction

   function automatic rsp_type apply_multiset(req_type r);
      rsp_type     o;
      int unsigned held;
      int unsigned idx;
      int unsigned take;
      o = '0;
      held = key_counts.exists(r.key) ? key_counts[r.key] : 0;
      case (r.action)
         ACT_INSERT, ACT_RANK_INS: begin
            if (r.action == ACT_RANK_INS) o.answer = 20'(rank_of(r.key));
            if (set_size >= 20'hFFFFF) begin
               o.error_flag = 1'b1;
            end else begin
               key_counts[r.key] = held + 1;
               set_size++;
            end
         end
         ACT_ERASE_ALL, ACT_ERASE_AMT: begin
            take = (r.action == ACT_ERASE_AMT && r.amount < held) ? 32'(r.amount) : held;
            set_size -= take;
            if (take == held) key_counts.delete(r.key);
            else key_counts[r.key] = held - take;
         end
         ACT_COUNT: o.answer = 20'(held);
         ACT_RANK:  o.answer = 20'(rank_of(r.key));
         ACT_SELECT: begin
            if (r.amount >= set_size) begin
               o.error_flag = 1'b1;
               o.answer = 20'hFFFF;
            end else begin
               idx = 32'(r.amount);
               foreach (key_counts[k]) begin
                  if (idx < key_counts[k]) begin
                     o.answer = 20'(k);
                     break;
                  end
                  idx -= key_counts[k];
               end
            end
         end
         default: begin
            key_counts.delete();
            set_size = 0;
            clear_count++;
         end
      endcase
      o.total_size = 20'(set_size);
      return o;
   endfunction

   // drive one transaction and wait for acceptance
   task automatic push_item(req_type r, bit fixed, rsp_type fixed_rsp);
      rsp_type predicted;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      predicted = apply_multiset(r);
      expected_rsp.push_back(fixed ? fixed_rsp : predicted);
   endtask

   function automatic req_type random_item();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 999);
      if (pick < 2) r.action = ACT_CLEAR;
      else if (pick < 300) r.action = ACT_INSERT;
      else if (pick < 450) r.action = ACT_RANK_INS;
      else if (pick < 530) r.action = ACT_ERASE_ALL;
      else if (pick < 640) r.action = ACT_ERASE_AMT;
      else if (pick < 740) r.action = ACT_COUNT;
      else if (pick < 860) r.action = ACT_RANK;
      else r.action = ACT_SELECT;
      case ($urandom_range(0, 9))
         0:       r.key = 16'($urandom);
         1:       r.key = 16'(16'hFFFF - $urandom_range(0, 3));
         default: r.key = 16'($urandom_range(0, 40) * 1601);
      endcase
      if ($urandom_range(0, 7) == 0) r.amount = 20'($urandom);
      else r.amount = 20'($urandom_range(0, set_size + 3));
      return r;
   endfunction

   function automatic void add_row(logic [2:0] act, bit [15:0] key, bit [19:0] amt,
                                   bit fixed = 1'b0, bit [19:0] ans = '0,
                                   bit [19:0] sz = '0, bit err = 1'b0);
      row_type t;
      t.req = '{action: act, key: key, amount: amt};
      t.fixed = fixed;
      t.rsp = '{answer: ans, total_size: sz, error_flag: err};
      dir_rows.push_back(t);
   endfunction

   // response side: check, then decide next pop
   initial begin
      rsp_pop <= 1'b0;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_pop && !rsp_empty) begin
            rsp_count++;
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected transaction %h", $time, rsp_data);
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               if (e.answer !== rsp_data.answer) begin
                  $display("%0t: answer expected %0d actual %0d", $time, e.answer,
                           rsp_data.answer);
                  fail_count++;
               end
               if (e.total_size !== rsp_data.total_size) begin
                  $display("%0t: total_size expected %0d actual %0d", $time,
                           e.total_size, rsp_data.total_size);
                  fail_count++;
               end
               if (e.error_flag !== rsp_data.error_flag) begin
                  $display("%0t: error_flag expected %0b actual %0b", $time,
                           e.error_flag, rsp_data.error_flag);
                  fail_count++;
               end
            end
         end
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
         end
         @(posedge clock);
      end
   end

   initial begin
      int wait_cycles;
      fail_count = 0;
      rsp_count = 0;
      clear_count = 0;
      set_size = 0;
      hold_start = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_row(ACT_COUNT, 16'd5, 20'd0, 1'b1, 20'd0, 20'd0, 1'b0);
      add_row(ACT_SELECT, 16'd0, 20'd0, 1'b1, 20'hFFFF, 20'd0, 1'b1);
      add_row(ACT_INSERT, 16'h0000, 20'hFFFFF, 1'b1, 20'd0, 20'd1, 1'b0);
      add_row(ACT_INSERT, 16'hFFFF, 20'd0, 1'b1, 20'd0, 20'd2, 1'b0);
      add_row(ACT_INSERT, 16'hFFFF, 20'd0, 1'b1, 20'd0, 20'd3, 1'b0);
      add_row(ACT_RANK, 16'hFFFF, 20'd0, 1'b1, 20'd1, 20'd3, 1'b0);
      add_row(ACT_RANK, 16'h0000, 20'd0, 1'b1, 20'd0, 20'd3, 1'b0);
      add_row(ACT_SELECT, 16'd0, 20'd0, 1'b1, 20'd0, 20'd3, 1'b0);
      add_row(ACT_SELECT, 16'd0, 20'd2, 1'b1, 20'hFFFF, 20'd3, 1'b0);
      add_row(ACT_SELECT, 16'd0, 20'd3, 1'b1, 20'hFFFF, 20'd3, 1'b1);
      add_row(ACT_SELECT, 16'd0, 20'hFFFFF, 1'b1, 20'hFFFF, 20'd3, 1'b1);
      add_row(ACT_RANK_INS, 16'h8000, 20'd0, 1'b1, 20'd1, 20'd4, 1'b0);
      add_row(ACT_RANK_INS, 16'h7FFF, 20'd0);
      add_row(ACT_COUNT, 16'hFFFF, 20'd0, 1'b1, 20'd2, 20'd5, 1'b0);
      add_row(ACT_ERASE_AMT, 16'hFFFF, 20'd1);
      add_row(ACT_ERASE_AMT, 16'h8000, 20'hFFFFF);
      add_row(ACT_ERASE_AMT, 16'h1234, 20'd7);
      add_row(ACT_ERASE_ALL, 16'h4321, 20'd0);
      add_row(ACT_INSERT, 16'h5555, 20'h55555);
      add_row(ACT_INSERT, 16'hAAAA, 20'hAAAAA);
      add_row(ACT_ERASE_ALL, 16'hFFFF, 20'd0);
      add_row(ACT_COUNT, 16'hAAAA, 20'd0);
      add_row(ACT_CLEAR, 16'hFFFF, 20'hFFFFF, 1'b1, 20'd0, 20'd0, 1'b0);
      add_row(ACT_RANK, 16'hFFFF, 20'd0, 1'b1, 20'd0, 20'd0, 1'b0);
      foreach (dir_rows[i]) push_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 75 : (phase == 3) ? 13 : 0;
         recv_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 13 : 0;
         for (int n = 0; n < 270; n++) begin
            if (phase == 0 && n == 100) hold_start = 1'b1;
            if (phase == 2 && n == 150) begin
               req_push <= 1'b0;
               wait (expected_rsp.size() == 0);
               @(posedge clock);
            end
            push_item(random_item(), 1'b0, '0);
         end
      end
      req_push <= 1'b0;

      wait_cycles = 0;
      while (expected_rsp.size() != 0 && wait_cycles < 2_000_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $display("%0d transactions never answered", expected_rsp.size());
         fail_count++;
      end
      $display("covered %0d responses, %0d clears, all eight actions, four idle phases",
               rsp_count, clear_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/osm_pkg.sv
hdl/osm_front.sv
hdl/osm_back.sv
hdl/order_statistic_multiset_top.sv
test/tb_top.sv
